### rtl/sgdm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgdm_pkg
// Types, constants and fixed-point helpers shared by the SGD momentum update
// pipeline: word formats, register indexes and saturating arithmetic.
// ---------------------------------------------------------------------------
package sgdm_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int SET_W     = 16;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int SPROD_W   = WORD_W + SET_W + 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic        [SET_W-1:0]   setting_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SPROD_W-1:0] sprod_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // One in Q0.16, needs one bit above the setting width
  localparam logic [SET_W:0] SET_ONE = (SET_W+1)'(1) << SET_W;

  localparam setting_t LR_RESET = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE = 3'd0,
    CFG_MOMENTUM      = 3'd1,
    CFG_DAMPENING     = 3'd2,
    CFG_DECAY         = 3'd3,
    CFG_NESTEROV      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    setting_t learning_rate;
    setting_t momentum_factor;
    setting_t dampening_factor;
    setting_t decay_factor;
    logic     nesterov_enable;
  } cfg_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } clip_t;

  // After gradient stage
  typedef struct packed {
    word_t param;
    word_t velocity;
    word_t mom_vel;
    word_t grad;
    logic  sat;
  } grad_t;

  // After momentum stage
  typedef struct packed {
    word_t param;
    word_t velocity;
    word_t step;
    logic  sat;
  } mom_t;

  typedef struct packed {
    word_t new_param;
    word_t new_velocity;
    logic  sat;
  } result_t;

  // Clip a wide signed value to the word range
  function automatic clip_t clip_word(prod_t x);
    logic [PROD_W-WORD_W:0] top;
    clip_t                  r;
    top = x[PROD_W-1:WORD_W-1];
    if ((top == '0) || (top == '1)) begin
      r.sat = 1'b0;
      r.val = x[WORD_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = x[PROD_W-1] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

  // Floor a setting product by the Q0.16 scale and clip
  function automatic clip_t scale_setting(sprod_t p);
    sprod_t sh;
    sh = p >>> SET_W;
    return clip_word(PROD_W'(sh));
  endfunction

  function automatic clip_t add_clip(word_t a, word_t b);
    logic signed [WORD_W:0] s;
    clip_t                  r;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      r.sat = 1'b1;
      r.val = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic clip_t sub_clip(word_t a, word_t b);
    logic signed [WORD_W:0] s;
    clip_t                  r;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      r.sat = 1'b1;
      r.val = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/sgdm_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgdm_cfg_regs
// Configuration register file: decodes plain writes into the optimiser
// settings and holds them for the pipeline.
// ---------------------------------------------------------------------------
module sgdm_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sgdm_pkg::SET_W-1:0]        cfg_data_i,
  output sgdm_pkg::cfg_t                    cfg_o
);
  import sgdm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEARNING_RATE: cfg_d.learning_rate    = cfg_data_i;
        CFG_MOMENTUM:      cfg_d.momentum_factor  = cfg_data_i;
        CFG_DAMPENING:     cfg_d.dampening_factor = cfg_data_i;
        CFG_DECAY:         cfg_d.decay_factor     = cfg_data_i;
        CFG_NESTEROV:      cfg_d.nesterov_enable  = cfg_data_i[0];
        default:           cfg_d = cfg_q; // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate    <= LR_RESET;
      cfg_q.momentum_factor  <= '0;
      cfg_q.dampening_factor <= '0;
      cfg_q.decay_factor     <= '0;
      cfg_q.nesterov_enable  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/sgdm_grad.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgdm_grad
// Gradient stages: delta times activation, coupled weight decay and the
// momentum-scaled old velocity. Two register stages.
// ---------------------------------------------------------------------------
module sgdm_grad (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgdm_pkg::cfg_t    cfg_i,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  sgdm_pkg::word_t   param_i,
  input  sgdm_pkg::word_t   velocity_i,
  input  sgdm_pkg::word_t   delta_i,
  input  sgdm_pkg::word_t   activation_i,
  output logic              down_valid_o,
  input  logic              down_ready_i,
  output sgdm_pkg::grad_t   down_data_o
);
  import sgdm_pkg::*;

  // Stage A: products
  logic   a_vld_q;
  word_t  a_param_q, a_vel_q;
  prod_t  a_da_q, a_da_d;
  sprod_t a_lw_q, a_lw_d;
  sprod_t a_mv_q, a_mv_d;
  // Stage B: gradient
  logic   b_vld_q;
  grad_t  b_q, b_d;

  logic a_rdy, b_rdy;
  logic decay_on, mom_on;
  clip_t g0, dw, gs, mv;

  assign b_rdy      = !b_vld_q || down_ready_i;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign up_ready_o = a_rdy;

  assign decay_on = (cfg_i.decay_factor != '0);
  assign mom_on   = (cfg_i.momentum_factor != '0);

  always_comb begin
    a_da_d = delta_i * activation_i;
    a_lw_d = $signed({1'b0, cfg_i.decay_factor}) * param_i;
    a_mv_d = $signed({1'b0, cfg_i.momentum_factor}) * velocity_i;
  end

  always_comb begin
    g0 = clip_word(a_da_q >>> FRAC_W);
    dw = scale_setting(a_lw_q);
    gs = add_clip(g0.val, dw.val);
    mv = scale_setting(a_mv_q);

    b_d.param    = a_param_q;
    b_d.velocity = a_vel_q;
    b_d.mom_vel  = mv.val;
    b_d.grad     = decay_on ? gs.val : g0.val;
    b_d.sat      = g0.sat | (decay_on & (dw.sat | gs.sat)) | (mom_on & mv.sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= up_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && up_valid_i) begin
      a_param_q <= param_i;
      a_vel_q   <= velocity_i;
      a_da_q    <= a_da_d;
      a_lw_q    <= a_lw_d;
      a_mv_q    <= a_mv_d;
    end
    if (b_rdy && a_vld_q) begin
      b_q <= b_d;
    end
  end

  assign down_valid_o = b_vld_q;
  assign down_data_o  = b_q;

endmodule

### rtl/sgdm_momentum.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgdm_momentum
// Momentum stages: dampened gradient into the velocity, then the optional
// Nesterov look-ahead. Four register stages.
// ---------------------------------------------------------------------------
module sgdm_momentum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgdm_pkg::cfg_t    cfg_i,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  sgdm_pkg::grad_t   up_data_i,
  output logic              down_valid_o,
  input  logic              down_ready_i,
  output sgdm_pkg::mom_t    down_data_o
);
  import sgdm_pkg::*;

  localparam int NSTG = 4;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;

  // Stage C: keep times gradient
  grad_t  c_q;
  sprod_t c_kg_q, c_kg_d;
  // Stage D: new velocity
  word_t  d_param_q, d_vel_q, d_grad_q, d_vn_q;
  logic   d_sat_q, d_sat_d;
  clip_t  kg, vn;
  // Stage E: momentum times new velocity
  word_t  e_param_q, e_vel_q, e_grad_q, e_vn_q;
  logic   e_sat_q;
  sprod_t e_mvn_q, e_mvn_d;
  // Stage F: step
  mom_t   f_q, f_d;
  clip_t  nv, ns;

  logic           mom_on;
  logic [SET_W:0] keep;

  assign mom_on = (cfg_i.momentum_factor != '0);
  assign keep   = SET_ONE - {1'b0, cfg_i.dampening_factor};

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || down_ready_i;
    for (int k = NSTG-2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end
  assign up_ready_o = rdy[0];

  always_comb begin
    c_kg_d  = $signed({1'b0, keep}) * up_data_i.grad;

    kg      = scale_setting(c_kg_q);
    vn      = add_clip(c_q.mom_vel, kg.val);
    d_sat_d = c_q.sat | (mom_on & (kg.sat | vn.sat));

    e_mvn_d = $signed({1'b0, cfg_i.momentum_factor}) * d_vn_q;

    nv = scale_setting(e_mvn_q);
    ns = add_clip(e_grad_q, nv.val);
    f_d.param = e_param_q;
    if (!mom_on) begin
      f_d.velocity = e_vel_q;
      f_d.step     = e_grad_q;
      f_d.sat      = e_sat_q;
    end else if (cfg_i.nesterov_enable) begin
      f_d.velocity = e_vn_q;
      f_d.step     = ns.val;
      f_d.sat      = e_sat_q | nv.sat | ns.sat;
    end else begin
      f_d.velocity = e_vn_q;
      f_d.step     = e_vn_q;
      f_d.sat      = e_sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= up_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && up_valid_i) begin
      c_q    <= up_data_i;
      c_kg_q <= c_kg_d;
    end
    if (rdy[1] && vld_q[0]) begin
      d_param_q <= c_q.param;
      d_vel_q   <= c_q.velocity;
      d_grad_q  <= c_q.grad;
      d_vn_q    <= vn.val;
      d_sat_q   <= d_sat_d;
    end
    if (rdy[2] && vld_q[1]) begin
      e_param_q <= d_param_q;
      e_vel_q   <= d_vel_q;
      e_grad_q  <= d_grad_q;
      e_vn_q    <= d_vn_q;
      e_sat_q   <= d_sat_q;
      e_mvn_q   <= e_mvn_d;
    end
    if (rdy[3] && vld_q[2]) begin
      f_q <= f_d;
    end
  end

  assign down_valid_o = vld_q[NSTG-1];
  assign down_data_o  = f_q;

endmodule

### rtl/sgdm_apply.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgdm_apply
// Apply stages: learning rate times step, subtracted from the parameter.
// The second stage is the output register.
// ---------------------------------------------------------------------------
module sgdm_apply (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgdm_pkg::cfg_t    cfg_i,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  sgdm_pkg::mom_t    up_data_i,
  output logic              down_valid_o,
  input  logic              down_ready_i,
  output sgdm_pkg::result_t down_data_o
);
  import sgdm_pkg::*;

  logic    g_vld_q, h_vld_q;
  logic    g_rdy, h_rdy;
  word_t   g_param_q, g_vel_q;
  logic    g_sat_q;
  sprod_t  g_gs_q, g_gs_d;
  result_t h_q, h_d;
  clip_t   gs, nw;

  assign h_rdy      = !h_vld_q || down_ready_i;
  assign g_rdy      = !g_vld_q || h_rdy;
  assign up_ready_o = g_rdy;

  always_comb begin
    g_gs_d = $signed({1'b0, cfg_i.learning_rate}) * up_data_i.step;

    gs = scale_setting(g_gs_q);
    nw = sub_clip(g_param_q, gs.val);
    h_d.new_param    = nw.val;
    h_d.new_velocity = g_vel_q;
    h_d.sat          = g_sat_q | gs.sat | nw.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
    end else begin
      if (g_rdy) g_vld_q <= up_valid_i;
      if (h_rdy) h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_rdy && up_valid_i) begin
      g_param_q <= up_data_i.param;
      g_vel_q   <= up_data_i.velocity;
      g_sat_q   <= up_data_i.sat;
      g_gs_q    <= g_gs_d;
    end
    if (h_rdy && g_vld_q) begin
      h_q <= h_d;
    end
  end

  assign down_valid_o = h_vld_q;
  assign down_data_o  = h_q;

endmodule

### rtl/sgd_momentum_param_update.sv
// Each input transfer passes through registers A to H; H is the output register.
// Throughput: one item per cycle while the output is not stalled; four multiply
// stages alternate with four shift/clip/add stages; a stall holds each full stage
// that cannot pass its item on. Reset: valid bits clear at once; settings return
// to learning rate 655 and all other settings zero.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgd_momentum_param_update
// Fixed-point SGD step with momentum, dampening, coupled weight decay and
// optional Nesterov look-ahead, streamed one parameter per item.
// ---------------------------------------------------------------------------
module sgd_momentum_param_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sgdm_pkg::SET_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sgdm_pkg::word_t                param_value_i,
  input  sgdm_pkg::word_t                velocity_value_i,
  input  sgdm_pkg::word_t                delta_value_i,
  input  sgdm_pkg::word_t                activation_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sgdm_pkg::word_t                new_param_o,
  output sgdm_pkg::word_t                new_velocity_o,
  output logic                           saturated_o
);
  import sgdm_pkg::*;

  cfg_t    cfg;
  logic    in_rdy;
  logic    grad_vld, grad_rdy;
  grad_t   grad_data;
  logic    mom_vld, mom_rdy;
  mom_t    mom_data;
  result_t res;

  sgdm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sgdm_grad u_grad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .up_valid_i   (in_valid_i),
    .up_ready_o   (in_rdy),
    .param_i      (param_value_i),
    .velocity_i   (velocity_value_i),
    .delta_i      (delta_value_i),
    .activation_i (activation_value_i),
    .down_valid_o (grad_vld),
    .down_ready_i (grad_rdy),
    .down_data_o  (grad_data)
  );

  sgdm_momentum u_momentum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .up_valid_i   (grad_vld),
    .up_ready_o   (grad_rdy),
    .up_data_i    (grad_data),
    .down_valid_o (mom_vld),
    .down_ready_i (mom_rdy),
    .down_data_o  (mom_data)
  );

  sgdm_apply u_apply (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .up_valid_i   (mom_vld),
    .up_ready_o   (mom_rdy),
    .up_data_i    (mom_data),
    .down_valid_o (out_valid_o),
    .down_ready_i (!out_stall_i),
    .down_data_o  (res)
  );

  assign in_stall_o     = !in_rdy;
  assign new_param_o    = res.new_param;
  assign new_velocity_o = res.new_velocity;
  assign saturated_o    = res.sat;

endmodule
